/* rtl/core/kel_pkg.sv */
package kel_pkg;

    // fixed-point constants of the curve fit
    localparam logic [31:0] LOGC_RED_Q16 = 32'd21607136;
    localparam logic [21:0] EXP_RED_Q24  = 22'd2234805;
    localparam logic [31:0] LOGC_GRN_Q16 = 32'd18882375;
    localparam logic [21:0] EXP_GRN_Q24  = 22'd1266929;
    localparam logic [30:0] K_GRN_Q24    = 31'd1156753918;
    localparam logic [24:0] OFF_GRN_Q16  = 25'd10559132;
    localparam logic [30:0] K_BLU_Q24    = 31'd1610833773;
    localparam logic [24:0] OFF_BLU_Q16  = 25'd19991416;

    // reciprocal of 25 scaled by 2^32, rounded up
    localparam logic [27:0] RECIP_25     = 28'd171798692;

    // region limits in kelvin
    localparam logic [15:0] KELVIN_66    = 16'd6600;
    localparam logic [15:0] KELVIN_19    = 16'd1900;
    localparam logic [15:0] KELVIN_1     = 16'd100;

    // offsets of x in Q.8
    localparam logic [17:0] X_60         = 18'd15360;
    localparam logic [17:0] X_10         = 18'd2560;

    localparam int KEL_FIFO_DEPTH        = 2;

    // log2 as Q.16, used only to build constants
    function automatic logic [19:0] log2_q16(input logic [63:0] v, input int fb);
        int             p;
        int             i;
        logic [63:0]    m;
        logic [127:0]   sq;
        logic [15:0]    fr;
        p  = 0;
        fr = '0;
        for (i = 0; i < 64; i++)
        begin
            if (v[i])
                p = i;
        end
        if (v == 64'd0 || p < fb)
            return 20'd0;
        if (p >= 30)
            m = v >> (p - 30);
        else
            m = v << (30 - p);
        for (i = 0; i < 16; i++)
        begin
            sq = 128'(m) * 128'(m);
            m  = sq[93:30];
            fr = {fr[14:0], 1'b0};
            if (m >= 64'h8000_0000)
            begin
                m     = m >> 1;
                fr[0] = 1'b1;
            end
        end
        return 20'((p - fb) << 16) | 20'(fr);
    endfunction

    typedef logic [255:0][19:0] lut_t;

    function automatic lut_t make_lut();
        lut_t lut;
        int   n;
        for (n = 0; n < 256; n++)
            lut[n] = log2_q16(64'(n), 0);
        return lut;
    endfunction

    localparam lut_t        LOG_LUT = make_lut();
    localparam logic [19:0] LC_RED  = log2_q16(64'(LOGC_RED_Q16), 16);
    localparam logic [19:0] LC_GRN  = log2_q16(64'(LOGC_GRN_Q16), 16);

    // region flags of one word
    typedef struct packed {
        logic hi;      // above 6600 K: power curves for red and green
        logic bsat;    // at or above 6600 K: blue saturates
        logic bzero;   // at or below 1900 K: blue is off
        logic gzero;   // below 100 K: green is off
    } cls_t;

    // word passed from front to back
    typedef struct packed {
        logic [17:0] va;   // x or x-60, into the shared log unit
        logic [17:0] vb;   // x-10, into the blue log unit
        cls_t        cls;
    } word_t;

endpackage

/* rtl/core/kel_front.sv */
module kel_front
    import kel_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  take,
    input  logic  [15:0] kelvin,
    output logic  push,
    output word_t word
);

    logic        valid_reg;
    logic [43:0] prod_reg;
    cls_t        cls_reg;
    logic [17:0] x;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= take;
    end

    // scale by 64/25 and classify the region
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            prod_reg      <= 44'(kelvin) * 44'(RECIP_25);
            cls_reg.hi    <= kelvin > KELVIN_66;
            cls_reg.bsat  <= kelvin >= KELVIN_66;
            cls_reg.bzero <= kelvin <= KELVIN_19;
            cls_reg.gzero <= kelvin < KELVIN_1;
        end
    end

    // x in Q.8 and the log operands
    always_comb
    begin
        x        = prod_reg[43:26];
        word.va  = cls_reg.hi ? x - X_60 : x;
        word.vb  = x - X_10;
        word.cls = cls_reg;
        push     = valid_reg;
    end

endmodule

/* rtl/core/kel_fifo.sv */
module kel_fifo
    import kel_pkg::*;
#(
    parameter int DEPTH = KEL_FIFO_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  word_t wdata,
    output logic  full,
    output logic  pop,
    output word_t rdata
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    word_t             mem [DEPTH];
    logic [PW-1:0]     wr_reg;
    logic [PW-1:0]     rd_reg;
    logic [CW-1:0]     cnt_reg;
    logic              wr_en;

    // back end drains a word every cycle while the queue holds one
    assign pop   = cnt_reg != '0;
    assign full  = cnt_reg == CW'(DEPTH);
    assign wr_en = push && (!full || pop);
    assign rdata = mem[rd_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_reg] <= wdata;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (wr_en && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (!wr_en && pop)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

/* rtl/core/kel_log2.sv */
module kel_log2
    import kel_pkg::*;
(
    input  logic        clk,
    input  logic [17:0] v,
    output logic [19:0] lg
);

    logic [30:0] m_reg  [17];
    logic [15:0] fr_reg [17];
    logic [3:0]  ip_reg [17];
    logic        z_reg  [17];
    logic [4:0]  p;

    // leading one position
    always_comb
    begin
        p = 5'd0;
        for (int i = 0; i < 18; i++)
        begin
            if (v[i])
                p = 5'(i);
        end
    end

    // normalize to Q1.30
    always_ff @(posedge clk)
    begin
        m_reg[0]  <= 31'(v) << (5'd30 - p);
        ip_reg[0] <= 4'(p - 5'd8);
        z_reg[0]  <= v[17:8] == '0;
        fr_reg[0] <= '0;
    end

    // one fraction bit per squaring stage
    for (genvar s = 1; s < 17; s++)
    begin : g_sq
        logic [61:0] sq;
        logic [31:0] mn;
        assign sq = 62'(m_reg[s-1]) * 62'(m_reg[s-1]);
        assign mn = sq[61:30];
        always_ff @(posedge clk)
        begin
            m_reg[s]  <= mn[31] ? mn[31:1] : mn[30:0];
            fr_reg[s] <= {fr_reg[s-1][14:0], mn[31]};
            ip_reg[s] <= ip_reg[s-1];
            z_reg[s]  <= z_reg[s-1];
        end
    end

    assign lg = z_reg[16] ? 20'd0 : {ip_reg[16], fr_reg[16]};

endmodule

/* rtl/core/kel_back.sv */
module kel_back
    import kel_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop,
    input  word_t      word,
    output logic       done,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);

    typedef struct packed {
        logic        hi;
        logic        rz;
        logic        gz;
        logic [19:0] er;
        logic [19:0] eg;
        logic [7:0]  nr;
        logic [7:0]  ng;
        logic [7:0]  glo;
        logic [7:0]  blu;
    } srch_t;

    logic [19:0] la;
    logic [19:0] lb;
    cls_t        cls_reg [17];
    logic [16:0] vl_reg;
    logic        vm_reg;
    logic        vs_reg;
    logic [7:0]  vq_reg;
    cls_t        cm_reg;
    logic [41:0] sr_reg;
    logic [41:0] sg_reg;
    logic [50:0] pg_reg;
    logic [50:0] pb_reg;
    srch_t       srch_reg [9];
    srch_t       s_next;
    logic [17:0] sr;
    logic [17:0] sg;
    logic [51:0] dg;
    logic [51:0] db;
    logic [7:0]  lg_g;
    logic [7:0]  lg_b;
    logic        done_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;

    kel_log2 u_log_a (.clk(clk), .v(word.va), .lg(la));
    kel_log2 u_log_b (.clk(clk), .v(word.vb), .lg(lb));

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vl_reg   <= '0;
            vm_reg   <= 1'b0;
            vs_reg   <= 1'b0;
            vq_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vl_reg   <= {vl_reg[15:0], pop};
            vm_reg   <= vl_reg[16];
            vs_reg   <= vm_reg;
            vq_reg   <= {vq_reg[6:0], vs_reg};
            done_reg <= vq_reg[7];
        end
    end

    // region flags alongside the log units
    always_ff @(posedge clk)
    begin
        cls_reg[0] <= word.cls;
        for (int i = 1; i < 17; i++)
            cls_reg[i] <= cls_reg[i-1];
    end

    // scale the logs
    always_ff @(posedge clk)
    begin
        sr_reg <= 42'(EXP_RED_Q24) * 42'(la);
        sg_reg <= 42'(EXP_GRN_Q24) * 42'(la);
        pg_reg <= 51'(K_GRN_Q24) * 51'(la);
        pb_reg <= 51'(K_BLU_Q24) * 51'(lb);
        cm_reg <= cls_reg[16];
    end

    // power exponents and log channels
    always_comb
    begin
        sr   = sr_reg[41:24];
        sg   = sg_reg[41:24];
        dg   = 52'(pg_reg) - (52'(OFF_GRN_Q16) << 24);
        db   = 52'(pb_reg) - (52'(OFF_BLU_Q16) << 24);
        lg_g = (52'(pg_reg) <= (52'(OFF_GRN_Q16) << 24)) ? 8'd0 :
               (dg[51:40] > 12'd255) ? 8'd255 : dg[47:40];
        lg_b = (52'(pb_reg) <= (52'(OFF_BLU_Q16) << 24)) ? 8'd0 :
               (db[51:40] > 12'd255) ? 8'd255 : db[47:40];
        s_next.hi  = cm_reg.hi;
        s_next.rz  = 20'(sr) > LC_RED;
        s_next.gz  = 20'(sg) > LC_GRN;
        s_next.er  = LC_RED - 20'(sr);
        s_next.eg  = LC_GRN - 20'(sg);
        s_next.nr  = '0;
        s_next.ng  = '0;
        s_next.glo = cm_reg.gzero ? 8'd0 : lg_g;
        s_next.blu = cm_reg.bsat ? 8'd255 : cm_reg.bzero ? 8'd0 : lg_b;
    end

    always_ff @(posedge clk)
    begin
        srch_reg[0] <= s_next;
    end

    // bit-serial search for the largest n with log2(n) <= e
    for (genvar j = 0; j < 8; j++)
    begin : g_srch
        localparam logic [7:0] BIT = 8'(1 << (7 - j));
        logic [7:0] tr;
        logic [7:0] tg;
        srch_t      nx;
        always_comb
        begin
            tr    = srch_reg[j].nr | BIT;
            tg    = srch_reg[j].ng | BIT;
            nx    = srch_reg[j];
            if (LOG_LUT[tr] <= srch_reg[j].er)
                nx.nr = tr;
            if (LOG_LUT[tg] <= srch_reg[j].eg)
                nx.ng = tg;
        end
        always_ff @(posedge clk)
        begin
            srch_reg[j+1] <= nx;
        end
    end

    // final channel select
    always_ff @(posedge clk)
    begin
        red_reg   <= !srch_reg[8].hi ? 8'd255 : srch_reg[8].rz ? 8'd0 : srch_reg[8].nr;
        green_reg <= !srch_reg[8].hi ? srch_reg[8].glo :
                     srch_reg[8].gz ? 8'd0 : srch_reg[8].ng;
        blue_reg  <= srch_reg[8].blu;
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

/* rtl/core/kelvin_to_rgb.sv */
// kelvin_to_rgb: color temperature in kelvin to 8-bit red, green, blue.
// Input channel: a word (kelvin) is taken at a rising edge with start high
// and busy low. Output channel: done is high for one cycle with red, green
// and blue valid; the receiver takes it at the edge that ends that cycle.
// Throughput: one word per clock. busy rises only if the front-to-back
// queue fills, which does not happen as the back end drains every cycle.
// The 16 squaring stages of the log2 units and the 8-step search for the
// power-curve channels make up most of the pipeline from the edge that
// takes start to done.
// Reset: rst_n clears all valid flags and the queue; words in flight are
// dropped and no strobe follows until a new start is taken.
// The receiver cannot stall; every result appears exactly once.
module kelvin_to_rgb
    import kel_pkg::*;
#(
    parameter int FIFO_DEPTH = KEL_FIFO_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] kelvin,
    output logic        done,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);

    logic  take;
    logic  push;
    logic  full;
    logic  pop;
    word_t fw;
    word_t bw;

    assign busy = full;
    assign take = start && !busy;

    kel_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .kelvin (kelvin),
        .push   (push),
        .word   (fw)
    );

    kel_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (fw),
        .full  (full),
        .pop   (pop),
        .rdata (bw)
    );

    kel_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .pop   (pop),
        .word  (bw),
        .done  (done),
        .red   (red),
        .green (green),
        .blue  (blue)
    );

endmodule

/* bench/tb_top.sv */
module tb_top;
    import kel_pkg::*;

    localparam int PIPE_LAT    = 29;
    localparam int N_RANDOM    = 550;
    localparam int CYCLE_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] kelvin;
    logic        done;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // directed row: temperature, and an optional typed-in color
    typedef struct packed {
        logic [15:0] k;
        logic        known;
        rgb_t        color;
    } row_t;

    rgb_t   color_q[$];
    int     n_mismatch;
    int     cycles;
    int     send_gap;

    kelvin_to_rgb dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .kelvin (kelvin),
        .done   (done),
        .red    (red),
        .green  (green),
        .blue   (blue)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // log2 of v with fb fraction bits, as Q.16
    function automatic logic [63:0] lg2(input logic [63:0] v, input int fb);
        int          p;
        int          i;
        logic [63:0] m;
        logic [63:0] fr;
        p  = 0;
        fr = 64'd0;
        if (v == 64'd0)
            return 64'd0;
        for (i = 0; i < 64; i++)
        begin
            if (v[i])
                p = i;
        end
        if (p < fb)
            return 64'd0;
        if (p >= 30)
            m = v >> (p - 30);
        else
            m = v << (30 - p);
        for (i = 0; i < 16; i++)
        begin
            m  = (m * m) >> 30;
            fr = fr << 1;
            if (m >= 64'h8000_0000)
            begin
                m  = m >> 1;
                fr = fr | 64'd1;
            end
        end
        return (64'(p - fb) << 16) | fr;
    endfunction

    // power curve coef * d^-a through log domain and bit-serial search
    function automatic logic [7:0] power_curve(input logic [63:0] d, input logic [63:0] c,
                                               input logic [63:0] a);
        logic [63:0] lc;
        logic [63:0] s;
        logic [63:0] e;
        logic [7:0]  n;
        int          b;
        lc = lg2(c, 16);
        s  = (a * lg2(d, 8)) >> 24;
        if (s > lc)
            return 8'd0;
        e = lc - s;
        n = 8'd0;
        for (b = 7; b >= 0; b--)
        begin
            if (lg2(64'(n | (8'd1 << b)), 0) <= e)
                n = n | (8'd1 << b);
        end
        return n;
    endfunction

    // k*log2(v) - off, clamped
    function automatic logic [7:0] log_curve(input logic [63:0] v, input logic [63:0] k,
                                             input logic [63:0] off);
        logic [63:0] prod;
        logic [63:0] o;
        logic [63:0] n;
        prod = k * lg2(v, 8);
        o    = off << 24;
        if (prod <= o)
            return 8'd0;
        n = (prod - o) >> 40;
        return (n > 64'd255) ? 8'd255 : n[7:0];
    endfunction

    function automatic rgb_t predict_color(input logic [15:0] k);
        rgb_t        c;
        logic [63:0] x;
        x = (64'(k) * 64'd256) / 64'd100;
        if (k <= 16'd6600)
        begin
            c.r = 8'd255;
            c.g = (x < 64'd256) ? 8'd0 : log_curve(x, 64'(K_GRN_Q24), 64'(OFF_GRN_Q16));
        end
        else
        begin
            c.r = power_curve(x - 64'd15360, 64'(LOGC_RED_Q16), 64'(EXP_RED_Q24));
            c.g = power_curve(x - 64'd15360, 64'(LOGC_GRN_Q16), 64'(EXP_GRN_Q24));
        end
        if (k >= 16'd6600)
            c.b = 8'd255;
        else if (k <= 16'd1900)
            c.b = 8'd0;
        else
            c.b = log_curve(x - 64'd2560, 64'(K_BLU_Q24), 64'(OFF_BLU_Q16));
        return c;
    endfunction

    // compare each strobed word with the oldest expected color
    always @(posedge clk)
    begin
        rgb_t want;
        if (rst_n && done)
        begin
            if (color_q.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected word r=%0d g=%0d b=%0d", red, green, blue);
            end
            else
            begin
                want = color_q.pop_front();
                if (want.r !== red || want.g !== green || want.b !== blue)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                                 want.r, want.g, want.b, red, green, blue);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // issue one word, holding start until taken; start stays high for the next word
    task automatic send_word(input logic [15:0] k, input logic known, input rgb_t c);
        rgb_t p;
        while ($urandom_range(99) < send_gap)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        p = predict_color(k);
        if (known && p !== c)
        begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("table row k=%0d disagrees with predictor", k);
        end
        start  <= 1'b1;
        kelvin <= k;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        color_q.push_back(known ? c : p);
    endtask

    row_t table_rows[] = '{
        '{16'd0,     1'b1, '{8'd255, 8'd0,   8'd0}},
        '{16'd99,    1'b1, '{8'd255, 8'd0,   8'd0}},
        '{16'd100,   1'b0, '0},
        '{16'd101,   1'b0, '0},
        '{16'd1000,  1'b0, '0},
        '{16'd1900,  1'b0, '0},
        '{16'd1901,  1'b0, '0},
        '{16'd2000,  1'b0, '0},
        '{16'd4000,  1'b0, '0},
        '{16'd6500,  1'b0, '0},
        '{16'd6599,  1'b0, '0},
        '{16'd6600,  1'b0, '0},
        '{16'd6601,  1'b0, '0},
        '{16'd6700,  1'b0, '0},
        '{16'd10000, 1'b0, '0},
        '{16'd20000, 1'b0, '0},
        '{16'd40000, 1'b0, '0},
        '{16'd43690, 1'b0, '0},
        '{16'd21845, 1'b0, '0},
        '{16'd65535, 1'b0, '0}
    };

    initial
    begin
        int   i;
        int   ph;
        int   w;
        logic [15:0] k;
        n_mismatch = 0;
        cycles     = 0;
        send_gap   = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        kelvin     = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (table_rows[i])
            send_word(table_rows[i].k, table_rows[i].known, table_rows[i].color);

        // random words in three idle phases
        for (ph = 0; ph < 3; ph++)
        begin
            send_gap = (ph == 0) ? 8 : (ph == 1) ? 73 : 0;
            for (i = 0; i < N_RANDOM / 3; i++)
            begin
                w = $urandom_range(9);
                if (w < 5)
                    k = 16'($urandom_range(12000));
                else if (w < 7)
                    k = 16'($urandom_range(6620, 6580));
                else if (w < 8)
                    k = 16'($urandom_range(1920, 1880));
                else
                    k = 16'($urandom);
                send_word(k, 1'b0, '0);
                // pause until the pipe has drained
                if (i == 40)
                begin
                    start <= 1'b0;
                    while (color_q.size() != 0)
                        @(posedge clk);
                end
            end
        end

        start <= 1'b0;
        while (color_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 10) @(posedge clk);
        if (n_mismatch == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

/* files.f */
rtl/core/kel_pkg.sv
rtl/core/kel_front.sv
rtl/core/kel_fifo.sv
rtl/core/kel_log2.sv
rtl/core/kel_back.sv
rtl/core/kelvin_to_rgb.sv
bench/tb_top.sv
